/* rtl/oli_pkg.sv */
// Package for the ordered list block: field widths, operation and status codes,
// the item and result structs and the controller state type.
// Depends on nothing; the top level and the testbench refer to it by scoped names.
package oli_pkg;

    // Default sizes of the list storage.
    localparam int CAPACITY_DEF   = 64;
    localparam int ELEM_WIDTH_DEF = 32;

    // Fixed field widths of the item and result ports.
    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 6;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int LENGTH_W   = 7;

    // Operation codes; the two codes above read length do nothing.
    localparam logic [OPCODE_W-1:0] OP_INSERT_AT    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_AT    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_VALUE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_PUSH         = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_POP          = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_LENGTH       = 3'd5;

    // Status codes returned with every result.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    // One command item.
    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [POSITION_W-1:0] position;
        logic [VALUE_W-1:0]    value_in;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value_out;
        logic [LENGTH_W-1:0] length;
    } rsp_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_INS_LAST,
        ST_SCAN,
        ST_POP_WAIT
    } state_t;

endpackage

/* rtl/oli_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// Contents are undefined until written. Depends on nothing.
module oli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ordered_list_insert_remove.sv */
// Top level of the ordered list: command decode, shift and scan sequencer, entry count.
// Depends on oli_pkg and oli_ram.
//
//   port      | dir | type        | handshake
//   ----------+-----+-------------+----------------------------------------------
//   start/cmd | in  | oli_pkg::cmd_t | item taken at a clock edge with start high, busy low
//   done/rsp  | out | oli_pkg::rsp_t | one result per item, valid for the done cycle only
//
// Push, read length and every rejected item finish in the idle state; pop adds a read wait.
// Insert at moves the tail up one entry at a time, then writes the new word; remove at
// moves the entries after the position down; remove value reads every entry.
// The single read port of the entry RAM sets the pace: one entry moves per cycle.
// Reset clears the count and the controller; the entry RAM needs no clearing.
// The receiver cannot stall; a new item may be taken in the cycle its predecessor's
// result is shown.
module ordered_list_insert_remove #(
    parameter int CAPACITY   = oli_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = oli_pkg::ELEM_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  oli_pkg::cmd_t cmd,
    output logic          done,
    output oli_pkg::rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    oli_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   stop_reg, stop_next;
    logic            found_reg, found_next;
    logic            done_reg, done_next;
    logic [ELEM_WIDTH-1:0]         elem_reg, elem_next;
    logic [oli_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [oli_pkg::VALUE_W-1:0]   vout_reg, vout_next;

    // RAM port signals.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ELEM_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [ELEM_WIDTH-1:0] ram_rdata;

    // Width adaptation of the incoming word, the read word, position and count.
    logic [63:0]           key_wide;
    logic [ELEM_WIDTH-1:0] key_elem;
    logic [63:0]           rd_wide;
    logic [31:0]           pos_wide;
    logic [31:0]           cnt_wide;
    logic                  pos_in_range;
    logic                  list_full;
    logic [CW-1:0]         pos_idx;
    logic [CW-1:0]         pos_inc;
    logic [CW-1:0]         cnt_inc;
    logic [CW-1:0]         cnt_dec;
    logic [CW-1:0]         idx_inc;
    logic [CW-1:0]         idx_dec;
    logic                  match;

    assign key_wide     = 64'(cmd.value_in);
    assign key_elem     = key_wide[ELEM_WIDTH-1:0];
    assign rd_wide      = 64'(ram_rdata);
    assign pos_wide     = 32'(cmd.position);
    assign cnt_wide     = 32'(count_reg);
    assign pos_in_range = pos_wide < cnt_wide;
    assign list_full    = count_reg == CW'(CAPACITY);
    assign pos_idx      = pos_wide[CW-1:0];
    assign pos_inc      = pos_idx + CW'(1);
    assign cnt_inc      = count_reg + CW'(1);
    assign cnt_dec      = count_reg - CW'(1);
    assign idx_inc      = idx_reg + CW'(1);
    assign idx_dec      = idx_reg - CW'(1);
    assign match        = ram_rdata == elem_reg;

    // Entry storage. Within one item a write never hits the entry read in the same
    // cycle, and the next item is taken no earlier than the cycle after the last
    // write, so no forwarding is needed.
    oli_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oli_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        stop_reg   <= stop_next;
        found_reg  <= found_next;
        elem_reg   <= elem_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
    end

    // Sequencer: decode in idle, then shift up, scan and shift down, or wait for a pop.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        stop_next   = stop_reg;
        found_next  = found_reg;
        elem_next   = elem_reg;
        status_next = status_reg;
        vout_next   = vout_reg;
        done_next   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        unique case (state_reg)
            oli_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    elem_next   = key_elem;
                    status_next = oli_pkg::ST_OK;
                    vout_next   = '0;
                    unique case (cmd.opcode)
                        oli_pkg::OP_INSERT_AT:
                        begin
                            priority if (!pos_in_range)
                            begin
                                status_next = oli_pkg::ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (list_full)
                            begin
                                status_next = oli_pkg::ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                // Start moving the tail up from the last entry.
                                ram_re     = 1'b1;
                                ram_raddr  = cnt_dec[AW-1:0];
                                idx_next   = cnt_dec;
                                stop_next  = pos_idx;
                                state_next = oli_pkg::ST_SHIFT_UP;
                            end
                        end
                        oli_pkg::OP_REMOVE_AT:
                        begin
                            priority if (!pos_in_range)
                            begin
                                status_next = oli_pkg::ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (pos_inc == count_reg)
                            begin
                                // Removing the last entry moves nothing.
                                count_next = cnt_dec;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = pos_inc[AW-1:0];
                                idx_next   = pos_inc;
                                found_next = 1'b1;
                                state_next = oli_pkg::ST_SCAN;
                            end
                        end
                        oli_pkg::OP_REMOVE_VALUE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = oli_pkg::ST_MISSING;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                found_next = 1'b0;
                                state_next = oli_pkg::ST_SCAN;
                            end
                        end
                        oli_pkg::OP_PUSH:
                        begin
                            if (list_full)
                            begin
                                status_next = oli_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = key_elem;
                                count_next = cnt_inc;
                            end
                            done_next = 1'b1;
                        end
                        oli_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = oli_pkg::ST_MISSING;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = cnt_dec[AW-1:0];
                                state_next = oli_pkg::ST_POP_WAIT;
                            end
                        end
                        default:
                        begin
                            // Read length and the unused codes only report the count.
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            oli_pkg::ST_SHIFT_UP:
            begin
                // The entry read last cycle moves one place up.
                ram_we    = 1'b1;
                ram_waddr = idx_inc[AW-1:0];
                ram_wdata = ram_rdata;
                if (idx_reg == stop_reg)
                begin
                    state_next = oli_pkg::ST_INS_LAST;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[AW-1:0];
                    idx_next  = idx_dec;
                end
            end
            oli_pkg::ST_INS_LAST:
            begin
                // The new word fills the opened slot.
                ram_we     = 1'b1;
                ram_waddr  = stop_reg[AW-1:0];
                ram_wdata  = elem_reg;
                count_next = cnt_inc;
                done_next  = 1'b1;
                state_next = oli_pkg::ST_IDLE;
            end
            oli_pkg::ST_SCAN:
            begin
                // Before a match, compare; after it, move each entry one place down.
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_dec[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                else if (match)
                begin
                    found_next = 1'b1;
                end
                if (idx_reg == cnt_dec)
                begin
                    if (found_reg || match)
                    begin
                        count_next = cnt_dec;
                    end
                    else
                    begin
                        status_next = oli_pkg::ST_MISSING;
                    end
                    done_next  = 1'b1;
                    state_next = oli_pkg::ST_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc[AW-1:0];
                    idx_next  = idx_inc;
                end
            end
            oli_pkg::ST_POP_WAIT:
            begin
                vout_next  = rd_wide[31:0];
                count_next = cnt_dec;
                done_next  = 1'b1;
                state_next = oli_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = oli_pkg::ST_IDLE;
            end
        endcase
    end

    // Result item; the count register already holds the length after the operation.
    assign busy          = state_reg != oli_pkg::ST_IDLE;
    assign done          = done_reg;
    assign rsp.status    = status_reg;
    assign rsp.value_out = vout_reg;
    assign rsp.length    = cnt_wide[oli_pkg::LENGTH_W-1:0];

endmodule

/* dv/tb_ordered_list_insert_remove.sv */
// Self-checking testbench for ordered_list_insert_remove: a directed table, then random
// command phases, all checked against a list model kept inside the testbench.
// Depends on oli_pkg and the block's RTL.
module tb_ordered_list_insert_remove;

    localparam int CAPACITY = oli_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1425;
    localparam int DRAIN_CYCLES = 150;

    // Opcodes that the block ignores apart from reporting the length.
    localparam logic [oli_pkg::OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [oli_pkg::OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    // Marks a directed row whose result is typed into the table.
    localparam logic FIXED = 1'b1;
    localparam logic MODEL = 1'b0;

    // Random phase kinds.
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;
    localparam int PH_FILL   = 3;

    // Percent weights per phase: insert, remove at, remove value, push, pop, read length.
    // Whatever is left over goes to the spare opcodes.
    localparam int OP_MIX [4][6] = '{
        '{35,  5,  5, 45,  5, 3},
        '{ 3, 30, 30,  5, 28, 2},
        '{18, 17, 18, 18, 17, 9},
        '{25, 10, 10, 30, 15, 8}
    };

    typedef struct packed {
        oli_pkg::cmd_t cmd;
        logic          fixed;
        oli_pkg::rsp_t want;
    } row_t;

    // Directed rows: empty-list errors, ignored opcodes, extremes of every field,
    // end-of-list indexes, first-match removal and draining back to empty.
    localparam int DIRECTED_ROWS = 25;
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        {oli_pkg::OP_POP,          6'd0,  32'h0000_0000, FIXED, oli_pkg::ST_MISSING, 32'h0, 7'd0},
        {oli_pkg::OP_INSERT_AT,    6'd0,  32'hFFFF_FFFF, FIXED, oli_pkg::ST_RANGE,   32'h0, 7'd0},
        {oli_pkg::OP_REMOVE_AT,    6'd0,  32'h0000_0000, FIXED, oli_pkg::ST_RANGE,   32'h0, 7'd0},
        {oli_pkg::OP_REMOVE_AT,    6'd63, 32'hFFFF_FFFF, FIXED, oli_pkg::ST_RANGE,   32'h0, 7'd0},
        {oli_pkg::OP_REMOVE_VALUE, 6'd0,  32'h0000_0000, FIXED, oli_pkg::ST_MISSING, 32'h0, 7'd0},
        {oli_pkg::OP_LENGTH,       6'd0,  32'h0000_0000, FIXED, oli_pkg::ST_OK,      32'h0, 7'd0},
        {OP_SPARE_HI,              6'd63, 32'hFFFF_FFFF, FIXED, oli_pkg::ST_OK,      32'h0, 7'd0},
        {OP_SPARE_LO,              6'd21, 32'h5555_AAAA, FIXED, oli_pkg::ST_OK,      32'h0, 7'd0},
        {oli_pkg::OP_PUSH,         6'd63, 32'hFFFF_FFFF, FIXED, oli_pkg::ST_OK,      32'h0, 7'd1},
        {oli_pkg::OP_PUSH,         6'd0,  32'h0000_0000, FIXED, oli_pkg::ST_OK,      32'h0, 7'd2},
        {oli_pkg::OP_PUSH,         6'd42, 32'h8000_0001, FIXED, oli_pkg::ST_OK,      32'h0, 7'd3},
        {oli_pkg::OP_INSERT_AT,    6'd0,  32'h1234_5678, MODEL, oli_pkg::ST_OK,      32'h0, 7'd0},
        {oli_pkg::OP_INSERT_AT,    6'd3,  32'h0000_FFFF, MODEL, oli_pkg::ST_OK,      32'h0, 7'd0},
        {oli_pkg::OP_INSERT_AT,    6'd5,  32'hA5A5_A5A5, FIXED, oli_pkg::ST_RANGE,   32'h0, 7'd5},
        {oli_pkg::OP_INSERT_AT,    6'd63, 32'h0F0F_0F0F, FIXED, oli_pkg::ST_RANGE,   32'h0, 7'd5},
        {oli_pkg::OP_REMOVE_AT,    6'd63, 32'h0000_0000, FIXED, oli_pkg::ST_RANGE,   32'h0, 7'd5},
        {oli_pkg::OP_REMOVE_VALUE, 6'd0,  32'hFFFF_FFFF, MODEL, oli_pkg::ST_OK,      32'h0, 7'd0},
        {oli_pkg::OP_REMOVE_VALUE, 6'd0,  32'hDEAD_BEEF, FIXED, oli_pkg::ST_MISSING, 32'h0, 7'd4},
        {oli_pkg::OP_PUSH,         6'd0,  32'h0000_0000, MODEL, oli_pkg::ST_OK,      32'h0, 7'd0},
        {oli_pkg::OP_REMOVE_VALUE, 6'd0,  32'h0000_0000, MODEL, oli_pkg::ST_OK,      32'h0, 7'd0},
        {oli_pkg::OP_REMOVE_AT,    6'd0,  32'h0000_0000, MODEL, oli_pkg::ST_OK,      32'h0, 7'd0},
        {oli_pkg::OP_REMOVE_AT,    6'd2,  32'h0000_0000, MODEL, oli_pkg::ST_OK,      32'h0, 7'd0},
        {oli_pkg::OP_POP,          6'd0,  32'h0000_0000, MODEL, oli_pkg::ST_OK,      32'h0, 7'd0},
        {oli_pkg::OP_POP,          6'd0,  32'h0000_0000, MODEL, oli_pkg::ST_OK,      32'h0, 7'd0},
        {oli_pkg::OP_POP,          6'd0,  32'h0000_0000, FIXED, oli_pkg::ST_MISSING, 32'h0, 7'd0}
    };

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    oli_pkg::cmd_t cmd;
    logic          done;
    oli_pkg::rsp_t rsp;

    // Testbench copy of the list contents and its length.
    logic [oli_pkg::VALUE_W-1:0] list_words [CAPACITY];
    int list_len;
    int peak_len;

    oli_pkg::rsp_t pending_results [$];
    int fail_count;
    int item_count;
    int status_tally [4];
    bit no_gaps;

    ordered_list_insert_remove u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    // Free-running clock, period 2.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one operation to the list copy and returns the result it must produce.
    function automatic oli_pkg::rsp_t apply_to_list(oli_pkg::cmd_t c);
        oli_pkg::rsp_t r;
        int i;
        int hit;
        r.status = oli_pkg::ST_OK;
        r.value_out = '0;
        hit = -1;
        case (c.opcode)
            oli_pkg::OP_INSERT_AT:
            begin
                if (c.position >= list_len)
                    r.status = oli_pkg::ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = oli_pkg::ST_FULL;
                else
                begin
                    for (i = list_len; i > c.position; i--)
                        list_words[i] = list_words[i-1];
                    list_words[c.position] = c.value_in;
                    list_len++;
                end
            end
            oli_pkg::OP_REMOVE_AT, oli_pkg::OP_REMOVE_VALUE:
            begin
                if (c.opcode == oli_pkg::OP_REMOVE_AT)
                begin
                    if (c.position < list_len)
                        hit = c.position;
                    else
                        r.status = oli_pkg::ST_RANGE;
                end
                else
                begin
                    for (i = 0; i < list_len && hit < 0; i++)
                        if (list_words[i] == c.value_in)
                            hit = i;
                    if (hit < 0)
                        r.status = oli_pkg::ST_MISSING;
                end
                // Close the gap left by the removed entry.
                if (hit >= 0)
                begin
                    for (i = hit; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            oli_pkg::OP_PUSH:
            begin
                if (list_len >= CAPACITY)
                    r.status = oli_pkg::ST_FULL;
                else
                begin
                    list_words[list_len] = c.value_in;
                    list_len++;
                end
            end
            oli_pkg::OP_POP:
            begin
                if (list_len == 0)
                    r.status = oli_pkg::ST_MISSING;
                else
                begin
                    list_len--;
                    r.value_out = list_words[list_len];
                end
            end
            default:
            begin
            end
        endcase
        if (list_len > peak_len)
            peak_len = list_len;
        r.length = list_len[oli_pkg::LENGTH_W-1:0];
        return r;
    endfunction

    // Gap before an item: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Opcode drawn from the weights of the current phase.
    function automatic logic [oli_pkg::OPCODE_W-1:0] pick_opcode(int phase);
        int r;
        int acc;
        int k;
        r = $urandom_range(0, 99);
        acc = 0;
        if (phase == PH_FILL && list_len < CAPACITY && r < 70)
            return oli_pkg::OP_PUSH;
        for (k = 0; k < 6; k++)
        begin
            acc += OP_MIX[phase][k];
            if (r < acc)
                return oli_pkg::OP_INSERT_AT + k[oli_pkg::OPCODE_W-1:0];
        end
        return (r[0]) ? OP_SPARE_HI : OP_SPARE_LO;
    endfunction

    // Index mostly inside the list, sometimes at its end, sometimes anywhere.
    function automatic logic [oli_pkg::POSITION_W-1:0] pick_position();
        int r;
        int p;
        r = $urandom_range(0, 99);
        if (list_len > 0 && r < 75)
            p = $urandom_range(0, list_len - 1);
        else if (r < 85)
            p = list_len;
        else
            p = $urandom_range(0, 63);
        return p[oli_pkg::POSITION_W-1:0];
    endfunction

    // Word drawn so that duplicates and search hits are common.
    function automatic logic [oli_pkg::VALUE_W-1:0] pick_value(
        logic [oli_pkg::OPCODE_W-1:0] op
    );
        int r;
        r = $urandom_range(0, 99);
        if (op == oli_pkg::OP_REMOVE_VALUE && list_len > 0 && r < 60)
            return list_words[$urandom_range(0, list_len - 1)];
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return '1;
        else if (r < 30)
            return $urandom_range(0, 7);
        else
            return $urandom;
    endfunction

    // Presents one item after an optional gap and waits until the block takes it.
    task automatic issue_item(oli_pkg::cmd_t c, logic fixed, oli_pkg::rsp_t want);
        int gap;
        logic [63:0] junk;
        oli_pkg::rsp_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            junk = {$urandom, $urandom};
            start <= 1'b0;
            cmd <= junk[$bits(oli_pkg::cmd_t)-1:0];
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_to_list(c);
        pending_results.push_back(fixed ? want : predicted);
        item_count++;
    endtask

    // Results are compared in order with the oldest expectation.
    always @(posedge clk)
    begin
        oli_pkg::rsp_t want;
        if (rst_n && done)
        begin
            status_tally[rsp.status] = status_tally[rsp.status] + 1;
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: status %0d value %h length %0d",
                       rsp.status, rsp.value_out, rsp.length);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.value_out !== want.value_out)
                begin
                    $error("value_out: expected %h, got %h", want.value_out, rsp.value_out);
                    fail_count++;
                end
                if (rsp.length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, rsp.length);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, random phases, drain and verdict.
    initial
    begin
        oli_pkg::cmd_t c;
        int phase;
        int phase_len;
        int n;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        list_len = 0;
        peak_len = 0;
        fail_count = 0;
        item_count = 0;
        no_gaps = 1'b0;
        status_tally = '{0, 0, 0, 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIRECTED_ROWS; n++)
            issue_item(DIRECTED[n].cmd, DIRECTED[n].fixed, DIRECTED[n].want);

        // Random phases that grow, shrink, mix, or hold the list at its capacity.
        while (item_count < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            phase = $urandom_range(PH_GROW, PH_FILL);
            phase_len = $urandom_range(20, 120);
            no_gaps = ($urandom_range(0, 99) < 30);
            for (n = 0; n < phase_len && item_count < DIRECTED_ROWS + RANDOM_ITEMS; n++)
            begin
                c.opcode = pick_opcode(phase);
                c.position = pick_position();
                c.value_in = pick_value(c.opcode);
                issue_item(c, MODEL, '0);
            end
        end
        start <= 1'b0;

        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operations: %0d ok, %0d bad index, %0d full, %0d empty or missing.",
                 item_count, status_tally[oli_pkg::ST_OK], status_tally[oli_pkg::ST_RANGE],
                 status_tally[oli_pkg::ST_FULL], status_tally[oli_pkg::ST_MISSING]);
        $display("Longest list held: %0d of %0d entries.", peak_len, CAPACITY);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
